[hw/rtl/source_char_tokenizer_macros.svh]
// Assertion macros shared by the tokenizer RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef SOURCE_CHAR_TOKENIZER_MACROS_SVH
`define SOURCE_CHAR_TOKENIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define STZ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define STZ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/stz_pkg.sv]
// Shared types, widths, token codes and character constants of the tokenizer.
// No dependencies; every other RTL file except the macro header imports this package.
package stz_pkg;

   localparam int KEYWORD_COUNT_DEF = 4;
   localparam int KEYWORD_CHARS_DEF = 8;

   localparam int KEYWORD_W    = 64;
   localparam int PREFIX_CHARS = 8;
   localparam int CHAR_W       = 8;
   localparam int KIND_W       = 5;
   localparam int VALUE_W      = 31;
   localparam int LEN_W        = 16;
   localparam int LINE_W       = 16;
   localparam int COL_W        = 16;
   localparam int OFF_W        = 24;
   localparam int CSR_INDEX_W  = 3;

   localparam int MAX_RESULTS  = 3;
   localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
   localparam int FIFO_DEPTH   = 8;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_NUMBER    = 5'd0;
   localparam logic [KIND_W-1:0] KIND_WORD      = 5'd1;
   localparam logic [KIND_W-1:0] KIND_KEYWORD   = 5'd2;
   localparam logic [KIND_W-1:0] KIND_STRING    = 5'd3;
   localparam logic [KIND_W-1:0] KIND_ADD       = 5'd4;
   localparam logic [KIND_W-1:0] KIND_SUB       = 5'd5;
   localparam logic [KIND_W-1:0] KIND_MUL       = 5'd6;
   localparam logic [KIND_W-1:0] KIND_DIV       = 5'd7;
   localparam logic [KIND_W-1:0] KIND_ASSIGN    = 5'd8;
   localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd9;
   localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd10;
   localparam logic [KIND_W-1:0] KIND_LBRACKET  = 5'd11;
   localparam logic [KIND_W-1:0] KIND_RBRACKET  = 5'd12;
   localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd13;
   localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd14;
   localparam logic [KIND_W-1:0] KIND_QUOTE     = 5'd15;
   localparam logic [KIND_W-1:0] KIND_ERROR     = 5'd16;

   // characters
   localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CH_QUOTE    = 8'h22;
   localparam logic [CHAR_W-1:0] CH_LPAREN   = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN   = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_EQUAL    = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_LBRACE   = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE   = 8'h7D;

   typedef logic [KEYWORD_W-1:0] keyword_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [LEN_W-1:0]   length;
      logic [LINE_W-1:0]  line;
      logic [COL_W-1:0]   column;
      logic [OFF_W-1:0]   offset;
      logic               last;
   } tok_type;

   typedef tok_type [MAX_RESULTS-1:0] tok_vec_type;

   // tokens produced by one character, slot 0 first
   typedef struct packed {
      logic [RES_CNT_W-1:0] count;
      tok_vec_type          toks;
   } push_type;

endpackage

[hw/rtl/stz_req_if.sv]
// Character channel: valid/ready handshake carrying one source byte per word.
// Depends on stz_pkg for field widths.
interface stz_req_if
   import stz_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] source_char;
   logic              end_of_text;

   modport source (output valid, output source_char, output end_of_text, input ready);
   modport sink   (input valid, input source_char, input end_of_text, output ready);
endinterface

[hw/rtl/stz_rsp_if.sv]
// Token channel: valid/ready handshake carrying one token per word.
// Depends on stz_pkg for field widths.
interface stz_rsp_if
   import stz_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  token_kind;
   logic [VALUE_W-1:0] token_value;
   logic [LEN_W-1:0]   token_length;
   logic [LINE_W-1:0]  start_line;
   logic [COL_W-1:0]   start_column;
   logic [OFF_W-1:0]   start_offset;
   logic               run_last;

   modport source (output valid, output token_kind, output token_value, output token_length,
                   output start_line, output start_column, output start_offset,
                   output run_last, input ready);
   modport sink   (input valid, input token_kind, input token_value, input token_length,
                   input start_line, input start_column, input start_offset,
                   input run_last, output ready);
endinterface

[hw/rtl/stz_lexer.sv]
// Lexer state machine: consumes one character per step and forms up to three tokens.
// Depends on stz_pkg and source_char_tokenizer_macros.svh.
`include "source_char_tokenizer_macros.svh"

module stz_lexer
   import stz_pkg::*;
#(
   parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CHAR_W-1:0] char_in,
   input  logic              eot_in,
   input  keyword_type       keywords [KEYWORD_COUNT],
   output push_type          push
);

   typedef enum logic [2:0] {
      M_IDLE, M_WORD, M_NUMBER, M_STRING, M_COMMENT, M_SLASH, M_HALT
   } mode_type;

   localparam keyword_type KW_MASK = ~keyword_type'(0) << (KEYWORD_W - 8 * KEYWORD_CHARS);
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   mode_type              mode_ff, mode_in;
   keyword_type           prefix_ff, prefix_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [VALUE_W-1:0]    accum_ff, accum_in;
   logic [LINE_W-1:0]     line_ff, line_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [LINE_W-1:0]     sline_ff, sline_in;
   logic [COL_W-1:0]      scol_ff, scol_in;
   logic [OFF_W-1:0]      soff_ff, soff_in;

   logic                  used;
   logic [RES_CNT_W-1:0]  n;
   tok_vec_type           res;
   logic [KIND_W-1:0]     kind_k;
   logic [VALUE_W+3:0]    mul_sum;

   function automatic logic is_alpha(logic [CHAR_W-1:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
   endfunction

   function automatic logic is_digit(logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // single-character tokens; anything unknown maps to an error
   function automatic logic [KIND_W-1:0] single_kind(logic [CHAR_W-1:0] c);
      logic [KIND_W-1:0] k;
      case (c)
         CH_PLUS:     k = KIND_ADD;
         CH_MINUS:    k = KIND_SUB;
         CH_STAR:     k = KIND_MUL;
         CH_EQUAL:    k = KIND_ASSIGN;
         CH_LPAREN:   k = KIND_LPAREN;
         CH_RPAREN:   k = KIND_RPAREN;
         CH_LBRACKET: k = KIND_LBRACKET;
         CH_RBRACKET: k = KIND_RBRACKET;
         CH_LBRACE:   k = KIND_LBRACE;
         CH_RBRACE:   k = KIND_RBRACE;
         default:     k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [LEN_W-1:0] sat16(logic [LEN_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [OFF_W-1:0] sat24(logic [OFF_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic tok_type make_tok(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                                        logic [LEN_W-1:0] len, logic [LINE_W-1:0] ln,
                                        logic [COL_W-1:0] col, logic [OFF_W-1:0] off);
      tok_type t;
      t.kind   = kind;
      t.value  = value;
      t.length = len;
      t.line   = ln;
      t.column = col;
      t.offset = off;
      t.last   = 1'b0;
      return t;
   endfunction

   function automatic tok_vec_type put(tok_vec_type v, logic [RES_CNT_W-1:0] idx, tok_type t);
      tok_vec_type r;
      r = v;
      case (idx)
         2'd0:    r[0] = t;
         2'd1:    r[1] = t;
         default: r[2] = t;
      endcase
      return r;
   endfunction

   // word or keyword; lowest matching keyword index wins
   function automatic tok_type word_tok(keyword_type pfx, logic [LEN_W-1:0] len,
                                        logic [LINE_W-1:0] ln, logic [COL_W-1:0] col,
                                        logic [OFF_W-1:0] off, keyword_type kws [KEYWORD_COUNT]);
      logic               hit;
      logic [VALUE_W-1:0] idx;
      hit = 1'b0;
      idx = '0;
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
         if ((kws[i] & KW_MASK) == pfx) begin
            hit = 1'b1;
            idx = VALUE_W'(i);
         end
      end
      if (hit && len <= LEN_W'(KEYWORD_CHARS)) begin
         return make_tok(KIND_KEYWORD, idx, len, ln, col, off);
      end
      return make_tok(KIND_WORD, '0, len, ln, col, off);
   endfunction

   always_comb begin
      mode_in   = mode_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;
      accum_in  = accum_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      off_in    = off_ff;
      sline_in  = sline_ff;
      scol_in   = scol_ff;
      soff_in   = soff_ff;
      used      = 1'b0;
      n         = '0;
      res       = '0;
      kind_k    = KIND_ERROR;
      mul_sum   = '0;

      if (step && mode_ff != M_HALT) begin
         // finish or extend the pending token
         case (mode_ff)
            M_WORD: begin
               if (is_alpha(char_in)) begin
                  for (int j = 0; j < PREFIX_CHARS; j++) begin
                     if (len_in == LEN_W'(j)) prefix_in[KEYWORD_W-1-8*j -: CHAR_W] = char_in;
                  end
                  len_in = sat16(len_in);
                  col_in = sat16(col_in);
                  off_in = sat24(off_in);
                  used   = 1'b1;
               end else begin
                  res     = put(res, n, word_tok(prefix_in, len_in, sline_in, scol_in,
                                                 soff_in, keywords));
                  n       = n + 1'b1;
                  mode_in = M_IDLE;
               end
            end
            M_NUMBER: begin
               if (is_digit(char_in)) begin
                  mul_sum  = {accum_in, 3'b000} + {2'b00, accum_in, 1'b0}
                           + (VALUE_W + 4)'(char_in - CH_ZERO);
                  accum_in = (mul_sum > (VALUE_W + 4)'(VALUE_MAX)) ? VALUE_MAX
                                                                   : mul_sum[VALUE_W-1:0];
                  len_in   = sat16(len_in);
                  col_in   = sat16(col_in);
                  off_in   = sat24(off_in);
                  used     = 1'b1;
               end else begin
                  res     = put(res, n, make_tok(KIND_NUMBER, accum_in, len_in, sline_in,
                                                 scol_in, soff_in));
                  n       = n + 1'b1;
                  mode_in = M_IDLE;
               end
            end
            M_STRING: begin
               if (char_in == CH_QUOTE) begin
                  res     = put(res, n, make_tok(KIND_STRING, '0, len_in, sline_in,
                                                 scol_in, soff_in));
                  n       = n + 1'b1;
                  res     = put(res, n, make_tok(KIND_QUOTE, '0, LEN_W'(1), line_in,
                                                 col_in, off_in));
                  n       = n + 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  len_in = sat16(len_in);
               end
               col_in = sat16(col_in);
               off_in = sat24(off_in);
               used   = 1'b1;
            end
            M_COMMENT: begin
               if (char_in == CH_NEWLINE) begin
                  mode_in = M_IDLE;
               end else begin
                  col_in = sat16(col_in);
                  off_in = sat24(off_in);
                  used   = 1'b1;
               end
            end
            M_SLASH: begin
               if (char_in == CH_SLASH) begin
                  mode_in = M_COMMENT;
                  col_in  = sat16(col_in);
                  off_in  = sat24(off_in);
                  used    = 1'b1;
               end else begin
                  res     = put(res, n, make_tok(KIND_DIV, '0, len_in, sline_in,
                                                 scol_in, soff_in));
                  n       = n + 1'b1;
                  mode_in = M_IDLE;
               end
            end
            default: begin
               mode_in = M_IDLE;
            end
         endcase

         // start a new token from this character
         if (!used) begin
            if (char_in == CH_NEWLINE) begin
               line_in = sat16(line_in);
               col_in  = COL_W'(1);
               off_in  = sat24(off_in);
            end else if (char_in == CH_SPACE || char_in == CH_TAB) begin
               col_in = sat16(col_in);
               off_in = sat24(off_in);
            end else if (char_in == CH_SLASH || is_alpha(char_in) || is_digit(char_in)) begin
               sline_in = line_in;
               scol_in  = col_in;
               soff_in  = off_in;
               len_in   = LEN_W'(1);
               if (char_in == CH_SLASH) begin
                  mode_in = M_SLASH;
               end else if (is_alpha(char_in)) begin
                  prefix_in = {char_in, {(KEYWORD_W - CHAR_W){1'b0}}};
                  mode_in   = M_WORD;
               end else begin
                  accum_in = VALUE_W'(char_in - CH_ZERO);
                  mode_in  = M_NUMBER;
               end
               col_in = sat16(col_in);
               off_in = sat24(off_in);
            end else if (char_in == CH_QUOTE) begin
               res      = put(res, n, make_tok(KIND_QUOTE, '0, LEN_W'(1), line_in,
                                               col_in, off_in));
               n        = n + 1'b1;
               col_in   = sat16(col_in);
               off_in   = sat24(off_in);
               sline_in = line_in;
               scol_in  = col_in;
               soff_in  = off_in;
               len_in   = '0;
               mode_in  = M_STRING;
            end else begin
               kind_k = single_kind(char_in);
               res    = put(res, n, make_tok(kind_k, '0, LEN_W'(1), line_in, col_in, off_in));
               n      = n + 1'b1;
               if (kind_k == KIND_ERROR) begin
                  mode_in = M_HALT;
               end else begin
                  col_in = sat16(col_in);
                  off_in = sat24(off_in);
               end
            end
         end

         // end of text: flush what is pending, then return to the reset state
         if (eot_in && mode_in != M_HALT) begin
            case (mode_in)
               M_WORD: begin
                  res = put(res, n, word_tok(prefix_in, len_in, sline_in, scol_in,
                                             soff_in, keywords));
                  n   = n + 1'b1;
               end
               M_NUMBER: begin
                  res = put(res, n, make_tok(KIND_NUMBER, accum_in, len_in, sline_in,
                                             scol_in, soff_in));
                  n   = n + 1'b1;
               end
               M_STRING: begin
                  res = put(res, n, make_tok(KIND_STRING, '0, len_in, sline_in,
                                             scol_in, soff_in));
                  n   = n + 1'b1;
               end
               M_SLASH: begin
                  res = put(res, n, make_tok(KIND_DIV, '0, len_in, sline_in,
                                             scol_in, soff_in));
                  n   = n + 1'b1;
               end
               default: begin
               end
            endcase
            mode_in   = M_IDLE;
            prefix_in = '0;
            len_in    = '0;
            accum_in  = '0;
            line_in   = LINE_W'(1);
            col_in    = COL_W'(1);
            off_in    = '0;
            sline_in  = LINE_W'(1);
            scol_in   = COL_W'(1);
            soff_in   = '0;
         end

         case (n)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: begin
            end
         endcase
      end
   end

   assign push.count = n;
   assign push.toks  = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         prefix_ff <= '0;
         len_ff    <= '0;
         accum_ff  <= '0;
         line_ff   <= LINE_W'(1);
         col_ff    <= COL_W'(1);
         off_ff    <= '0;
         sline_ff  <= LINE_W'(1);
         scol_ff   <= COL_W'(1);
         soff_ff   <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         prefix_ff <= prefix_in;
         len_ff    <= len_in;
         accum_ff  <= accum_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         off_ff    <= off_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         soff_ff   <= soff_in;
      end
   end

   `STZ_ASSERT_NOW(halt_is_silent, mode_ff == M_HALT, n == '0, "tokens produced while halted")
   `STZ_ASSERT_NEXT(halt_holds, mode_ff == M_HALT, mode_ff == M_HALT, "left halt without reset")
   `STZ_ASSERT_NEXT(eot_restarts, step && eot_in && mode_in != M_HALT,
                    mode_ff == M_IDLE && line_ff == LINE_W'(1) && col_ff == COL_W'(1) && off_ff == '0,
                    "position not restarted after end of text")

endmodule

[hw/rtl/stz_result_fifo.sv]
// Token queue: takes up to three tokens a cycle from the lexer, drains one per rsp word.
// Depends on stz_pkg, stz_rsp_if and source_char_tokenizer_macros.svh.
`include "source_char_tokenizer_macros.svh"

module stz_result_fifo
   import stz_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  push_type          push,
   output logic              room,
   stz_rsp_if.source         rsp
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   tok_type            mem [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;
   tok_type            head;

   assign pop      = rsp.valid && rsp.ready;
   assign count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   assign room     = count_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS);

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (RES_CNT_W'(k) < push.count) mem[wr_ptr_ff + PTR_W'(k)] <= push.toks[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push.count);
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   assign head             = mem[rd_ptr_ff];
   assign rsp.valid        = count_ff != '0;
   assign rsp.token_kind   = head.kind;
   assign rsp.token_value  = head.value;
   assign rsp.token_length = head.length;
   assign rsp.start_line   = head.line;
   assign rsp.start_column = head.column;
   assign rsp.start_offset = head.offset;
   assign rsp.run_last     = head.last;

   `STZ_ASSERT_NOW(push_fits, push.count != '0,
                   count_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS), "push without room")
   `STZ_ASSERT_NOW(count_bound, 1'b1, count_ff <= CNT_W'(FIFO_DEPTH), "queue overflow")
   `STZ_ASSERT_NEXT(drain_empties, pop && count_ff == CNT_W'(1) && push.count == '0,
                    !rsp.valid, "queue not empty after last token left")

endmodule

[hw/rtl/source_char_tokenizer.sv]
// Streaming tokenizer: accepts one source character per cycle and returns tokens
// (numbers, words, keywords, strings, operators, brackets, quotes, error) with their
// start line, column, offset and length. A character is taken into an input register,
// processed by the lexer once the queue has room, and its zero to three tokens are
// written to an eight-entry queue. One character enters per cycle as long as the queue
// has room for three more tokens, and tokens leave at one per cycle while the token
// port is ready, so a run of characters that each close more than one token is paced by
// the token port. Keyword registers are written through the csr port; the user must do
// so only while the block is idle, unchecked; an error token halts the lexer until reset.
module source_char_tokenizer
   import stz_pkg::*;
#(
   parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   stz_req_if.sink                req_chan,
   stz_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [KEYWORD_W-1:0]   csr_wdata
);

   keyword_type        kw_ff [KEYWORD_COUNT];
   logic               in_valid_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               eot_ff;
   logic               room;
   logic               process;
   push_type           push;

   assign process        = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || process;

   // keyword registers; writes beyond the configured count are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEYWORD_COUNT; i++) kw_ff[i] <= '0;
      end else if (csr_wr_en) begin
         for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (csr_index == CSR_INDEX_W'(i)) kw_ff[i] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         char_ff <= req_chan.source_char;
         eot_ff  <= req_chan.end_of_text;
      end
   end

   stz_lexer #(
      .KEYWORD_COUNT (KEYWORD_COUNT),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_lexer (
      .clock    (clock),
      .reset    (reset),
      .step     (process),
      .char_in  (char_ff),
      .eot_in   (eot_ff),
      .keywords (kw_ff),
      .push     (push)
   );

   stz_result_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_chan)
   );

endmodule
